// ===== sv/mrq_pkg.sv =====
`timescale 1ns / 1ps

package mrq_pkg;

  // Field widths
  localparam int ID_W     = 16;
  localparam int PRIO_W   = 3;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;
  localparam int CFG_W    = 5;

  // Parameter defaults
  localparam int CAPACITY_DEF = 16;
  localparam int LEVELS_DEF   = 4;

  // max_entries after reset
  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd16;

  typedef logic [STATUS_W-1:0] status_t;

  // Result status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_BAD_PRIO  = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_NOT_FOUND = 2'd3;

  // Request function codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

endpackage

// ===== sv/multilevel_ready_queue.sv =====
`timescale 1ns / 1ps
// Insert writes the new slot unless rejected, then scans for the head; remove runs a search pass,
// a shift pass and a head scan, skipping the shift pass when the id is absent.
// Throughput: one request at a time, next taken the cycle after the result registers.
// Reset (rst_n low, synchronous): count zero, max_entries 16, no result pending; slot store is not
// cleared, since only slots below the count are ever read.
module multilevel_ready_queue import mrq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int LEVELS   = LEVELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_func,
  input  logic [ID_W-1:0]   in_proc_id,
  input  logic [PRIO_W-1:0] in_priority_req,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output status_t           out_status,
  output logic              out_next_valid,
  output logic [ID_W-1:0]   out_next_id,
  output logic [OCC_W-1:0]  out_occupancy,
  // configuration write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_max_entries
);

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ENTRY_W = ID_W + LVL_W;
  localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_pos_r, rd_pos_nxt;
  logic             found_r, found_nxt;
  logic [LVL_W-1:0] best_lvl_r, best_lvl_nxt;
  logic [ID_W-1:0]  best_id_r, best_id_nxt;
  logic [IDX_W-1:0] match_r, match_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  status_t          status_r, status_nxt;
  logic [CFG_W-1:0] max_r, max_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic             out_nv_r, out_nv_nxt;
  logic [ID_W-1:0]  out_id_r, out_id_nxt;
  logic [OCC_W-1:0] out_occ_r, out_occ_nxt;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;
  logic [ID_W-1:0]    rd_id;
  logic [LVL_W-1:0]   rd_lvl;
  logic               pass_st;
  logic               rd_issue;
  logic               pass_end;
  logic               prio_bad;
  logic               full;
  logic               lvl_better;

  mrq_store #(
    .DEPTH   (CAPACITY),
    .ENTRY_W (ENTRY_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign rd_id  = rd_data[ID_W-1:0];
  assign rd_lvl = rd_data[ENTRY_W-1:ID_W];

  // Shared compare unit: level order for the search and scan passes
  assign lvl_better = !found_r || (rd_lvl < best_lvl_r);

  // Insert checks
  assign prio_bad = ({1'b0, in_priority_req} > 4'(LEVELS - 1));
  assign full     = (CMP_W'(held_r) >= CMP_W'(max_r)) || (held_r == CNT_W'(CAPACITY));

  // Pass read sequencing: one slot read issued per cycle
  assign pass_st  = (state_r == S_SEARCH) || (state_r == S_SHIFT) || (state_r == S_SCAN);
  assign rd_issue = pass_st && (idx_r < held_r);
  assign pass_end = !rd_issue && !rd_vld_r;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    held_nxt       = held_r;
    idx_nxt        = idx_r;
    rd_vld_nxt     = rd_issue;
    rd_pos_nxt     = idx_r[IDX_W-1:0];
    found_nxt      = found_r;
    best_lvl_nxt   = best_lvl_r;
    best_id_nxt    = best_id_r;
    match_nxt      = match_r;
    id_nxt         = id_r;
    status_nxt     = status_r;
    max_nxt        = max_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_nv_nxt     = out_nv_r;
    out_id_nxt     = out_id_r;
    out_occ_nxt    = out_occ_r;
    wr_en          = 1'b0;
    wr_addr        = held_r[IDX_W-1:0];
    wr_data        = {in_priority_req[LVL_W-1:0], in_proc_id};

    if (cfg_valid) begin
      max_nxt = cfg_max_entries;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (rd_issue) begin
      idx_nxt = idx_r + CNT_W'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          id_nxt    = in_proc_id;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          if (in_func == FUNC_REMOVE) begin
            state_nxt = S_SEARCH;
          end else begin
            state_nxt = S_SCAN;
            if (prio_bad) begin
              status_nxt = ST_BAD_PRIO;
            end else if (full) begin
              status_nxt = ST_FULL;
            end else begin
              wr_en      = 1'b1;
              held_nxt   = held_r + CNT_W'(1);
              status_nxt = ST_OK;
            end
          end
        end
      end
      // find first match: lowest level, then earliest slot
      S_SEARCH: begin
        if (rd_vld_r && (rd_id == id_r) && lvl_better) begin
          found_nxt    = 1'b1;
          best_lvl_nxt = rd_lvl;
          match_nxt    = rd_pos_r;
        end
        if (pass_end) begin
          found_nxt = 1'b0;
          if (found_r) begin
            state_nxt  = S_SHIFT;
            idx_nxt    = CNT_W'(match_r) + CNT_W'(1);
            status_nxt = ST_OK;
          end else begin
            state_nxt  = S_SCAN;
            idx_nxt    = '0;
            status_nxt = ST_NOT_FOUND;
          end
        end
      end
      // move later slots down by one
      S_SHIFT: begin
        if (rd_vld_r) begin
          wr_en   = 1'b1;
          wr_addr = rd_pos_r - IDX_W'(1);
          wr_data = rd_data;
        end
        if (pass_end) begin
          held_nxt  = held_r - CNT_W'(1);
          state_nxt = S_SCAN;
          idx_nxt   = '0;
          found_nxt = 1'b0;
        end
      end
      // head of lowest non-empty level
      S_SCAN: begin
        if (rd_vld_r && lvl_better) begin
          found_nxt    = 1'b1;
          best_lvl_nxt = rd_lvl;
          best_id_nxt  = rd_id;
        end
        if (pass_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_nv_nxt     = found_r;
          out_id_nxt     = found_r ? best_id_r : '0;
          out_occ_nxt    = OCC_W'(held_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      max_r       <= MAX_ENTRIES_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      found_r     <= found_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    rd_pos_r     <= rd_pos_nxt;
    best_lvl_r   <= best_lvl_nxt;
    best_id_r    <= best_id_nxt;
    match_r      <= match_nxt;
    id_r         <= id_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_nv_r     <= out_nv_nxt;
    out_id_r     <= out_id_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_next_valid = out_nv_r;
  assign out_next_id    = out_id_r;
  assign out_occupancy  = out_occ_r;

  // Checks
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_nv_r) |-> (out_occ_r == '0) && (out_id_r == '0))
    else $error("empty queue reported with entries or id");

  a_shift_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && pass_end) |=> held_r == $past(held_r) - CNT_W'(1))
    else $error("remove did not drop the count");

  a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_SHIFT) |=> $stable(held_r))
    else $error("count changed outside insert or shift");

endmodule

// ===== sv/mrq_store.sv =====
`timescale 1ns / 1ps

// Slot store: one write port, one read port with registered read data.
module mrq_store import mrq_pkg::*; #(
  parameter int DEPTH   = CAPACITY_DEF,
  parameter int ENTRY_W = ID_W + 2
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [ENTRY_W-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [ENTRY_W-1:0]         rd_data
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
